@@ src/lshs_pkg.sv @@
// ----------------------------------------------------------------------------
// lshs_pkg: shared types and constants of the limit switch homing sequencer
// Sizes, function codes, step reset values and the word formats that pass
// between the axis lanes, the merge stage and the output buffer.
// ----------------------------------------------------------------------------
package lshs_pkg;

   localparam int NUM_AXES       = 8;
   localparam int NUM_PHASES     = 6;
   localparam int SETPOINT_WIDTH = 32;

   localparam int NUM_REGS     = 6;
   localparam int NUM_SWITCHES = 8;
   localparam int OUT_AXES     = 8;
   localparam int OUT_W        = 32;
   localparam int VALUE_W      = 32;
   localparam int STEP_W       = 16;
   localparam int FUNC_W       = 2;
   localparam int AXIS_W       = 3;
   localparam int PHASE_OUT_W  = 3;
   localparam int REG_IDX_W    = 3;
   localparam int PHASE_W      = $clog2(NUM_PHASES + 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   localparam logic [NUM_REGS-1:0][STEP_W-1:0] STEP_RESET = {
      16'd1, 16'd1, 16'd1, 16'd5, 16'd5, 16'd5
   };

   typedef logic [SETPOINT_WIDTH-1:0] setpoint_type;

   typedef struct packed {
      logic              tick;
      logic              outward;
      logic [STEP_W-1:0] step;
   } lane_cmd_type;

   typedef struct packed {
      logic [PHASE_OUT_W-1:0] phase;
      logic                   busy;
      logic                   done;
   } status_type;

   typedef struct packed {
      logic [OUT_AXES-1:0][OUT_W-1:0] setpoint;
      status_type                     status;
   } result_type;

   function automatic setpoint_type to_setpoint(input logic signed [VALUE_W-1:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[SETPOINT_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input setpoint_type sp);
      logic [63:0] w;
      w = 64'(sp);
      return w[OUT_W-1:0];
   endfunction

endpackage

@@ src/lshs_lane.sv @@
// ----------------------------------------------------------------------------
// lshs_lane: one axis of the homing sequencer
// Holds the axis setpoint, applies loads and phase steps, and reports
// whether its switch already sits where the current phase wants it.
// ----------------------------------------------------------------------------
module lshs_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  lshs_pkg::lane_cmd_type cmd,
   input  logic                  load_en,
   input  lshs_pkg::setpoint_type load_value,
   input  logic                  sw,
   output logic                  settled,
   output lshs_pkg::setpoint_type setpoint_in
);

   lshs_pkg::setpoint_type setpoint_ff;
   lshs_pkg::setpoint_type step_ext;

   assign step_ext = lshs_pkg::SETPOINT_WIDTH'(cmd.step);
   assign settled  = cmd.outward ? sw : !sw;

   always_comb begin
      setpoint_in = setpoint_ff;
      if (load_en) begin
         setpoint_in = load_value;
      end else if (cmd.tick) begin
         if (cmd.outward && !sw) begin
            setpoint_in = setpoint_ff + step_ext;
         end else if (!cmd.outward && sw) begin
            setpoint_in = setpoint_ff - step_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
      end else begin
         setpoint_ff <= setpoint_in;
      end
   end

endmodule

@@ src/lshs_merge.sv @@
// ----------------------------------------------------------------------------
// lshs_merge: phase control of the homing sequencer
// Combines the settled flags of all lanes, advances the phase, holds the
// per-phase step registers and drives the common lane command.
// ----------------------------------------------------------------------------
module lshs_merge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  lshs_pkg::func_type                     func,
   input  logic [lshs_pkg::NUM_AXES-1:0]          settled,
   input  logic                                   csr_write,
   input  logic [lshs_pkg::REG_IDX_W-1:0]         csr_index,
   input  logic [lshs_pkg::STEP_W-1:0]            csr_wdata,
   output lshs_pkg::lane_cmd_type                 cmd,
   output lshs_pkg::status_type                   status,
   output logic                                   running
);

   logic [lshs_pkg::PHASE_W-1:0]                       phase_ff;
   logic [lshs_pkg::PHASE_W-1:0]                       phase_in;
   logic                                               running_ff;
   logic                                               running_in;
   logic [lshs_pkg::NUM_REGS-1:0][lshs_pkg::STEP_W-1:0] step_ff;
   logic [lshs_pkg::REG_IDX_W-1:0]                     step_idx;
   logic [lshs_pkg::PHASE_W:0]                         phase_inc;
   logic                                               all_settled;
   logic                                               done;

   assign all_settled = &settled;
   assign phase_inc   = {1'b0, phase_ff} + (lshs_pkg::PHASE_W + 1)'(1);
   assign running     = running_ff;

   always_comb begin
      if ({1'b0, phase_ff} < (lshs_pkg::PHASE_W + 1)'(lshs_pkg::NUM_REGS)) begin
         step_idx = lshs_pkg::REG_IDX_W'(phase_ff);
      end else begin
         step_idx = lshs_pkg::REG_IDX_W'(lshs_pkg::NUM_REGS - 1);
      end
   end

   always_comb begin
      cmd.tick    = accept && (func == lshs_pkg::FUNC_TICK) && running_ff;
      cmd.outward = !phase_ff[0];
      cmd.step    = step_ff[step_idx];
   end

   always_comb begin
      phase_in   = phase_ff;
      running_in = running_ff;
      done       = 1'b0;
      if (accept) begin
         case (func)
            lshs_pkg::FUNC_START: begin
               phase_in   = '0;
               running_in = 1'b1;
            end
            lshs_pkg::FUNC_TICK: begin
               if (running_ff && all_settled) begin
                  if (phase_inc >= (lshs_pkg::PHASE_W + 1)'(lshs_pkg::NUM_PHASES)) begin
                     phase_in   = lshs_pkg::PHASE_W'(lshs_pkg::NUM_PHASES);
                     running_in = 1'b0;
                     done       = 1'b1;
                  end else begin
                     phase_in = phase_inc[lshs_pkg::PHASE_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status.phase = lshs_pkg::PHASE_OUT_W'(phase_in);
      status.busy  = running_in;
      status.done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         running_ff <= 1'b0;
         step_ff    <= lshs_pkg::STEP_RESET;
      end else begin
         phase_ff   <= phase_in;
         running_ff <= running_in;
         if (csr_write && (csr_index < lshs_pkg::REG_IDX_W'(lshs_pkg::NUM_REGS))) begin
            step_ff[csr_index] <= csr_wdata;
         end
      end
   end

endmodule

@@ src/lshs_out.sv @@
// ----------------------------------------------------------------------------
// lshs_out: result buffer of the homing sequencer
// Output register plus one skid entry, so a new word is taken while the
// previous result still waits on a stalled consumer.
// ----------------------------------------------------------------------------
module lshs_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lshs_pkg::result_type push_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output lshs_pkg::result_type rsp_data,
   output logic                 full
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   lshs_pkg::result_type out_data_ff;
   lshs_pkg::result_type out_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   lshs_pkg::result_type skid_data_ff;
   lshs_pkg::result_type skid_data_in;
   logic                 out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign full      = skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

@@ src/limit_switch_homing_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// limit_switch_homing_sequencer_unit: eight-axis multi-pass homing sequencer
// Axis lanes, phase merge stage and result buffer.
// ----------------------------------------------------------------------------
// The block takes one word per clock while req_stall is low and gives one
// result word for each: every axis has its own adder lane that updates its
// setpoint in the accepting cycle, the merge stage decides the phase change in
// the same cycle, and the result lands in an output register backed by one
// skid entry, so req_stall rises only when both hold unread results.
// Configuration writes are always ready and take effect on the next word.
module limit_switch_homing_sequencer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lshs_pkg::FUNC_W-1:0]          req_func,
   input  logic [lshs_pkg::AXIS_W-1:0]          req_axis,
   input  logic signed [lshs_pkg::VALUE_W-1:0]  req_value,
   input  logic [lshs_pkg::NUM_SWITCHES-1:0]    req_switches,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_0,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_1,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_2,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_3,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_4,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_5,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_6,
   output logic signed [lshs_pkg::OUT_W-1:0]    rsp_setpoint_7,
   output logic [lshs_pkg::PHASE_OUT_W-1:0]     rsp_phase,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lshs_pkg::REG_IDX_W-1:0]       csr_index,
   input  logic [lshs_pkg::STEP_W-1:0]          csr_wdata
);

   logic                            accept;
   lshs_pkg::func_type              func;
   lshs_pkg::lane_cmd_type          cmd;
   lshs_pkg::status_type            status;
   logic                            running;
   logic [lshs_pkg::NUM_AXES-1:0]   settled;
   lshs_pkg::setpoint_type          load_value;
   lshs_pkg::result_type            result;
   lshs_pkg::result_type            rsp_data;
   logic                            full;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = full;
   assign csr_ready  = 1'b1;
   assign func       = lshs_pkg::func_type'(req_func);
   assign load_value = lshs_pkg::to_setpoint(req_value);

   lshs_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (func),
      .settled   (settled),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .running   (running)
   );

   for (genvar k = 0; k < lshs_pkg::OUT_AXES; k++) begin : g_axis
      if (k < lshs_pkg::NUM_AXES) begin : g_lane
         logic                   sw;
         logic                   load_en;
         lshs_pkg::setpoint_type setpoint_in;

         if (k < lshs_pkg::NUM_SWITCHES) begin : g_sw
            assign sw = req_switches[k];
         end else begin : g_nosw
            assign sw = 1'b0;
         end

         assign load_en = accept && (func == lshs_pkg::FUNC_LOAD)
                          && (req_axis == lshs_pkg::AXIS_W'(k));

         lshs_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .load_en     (load_en),
            .load_value  (load_value),
            .sw          (sw),
            .settled     (settled[k]),
            .setpoint_in (setpoint_in)
         );

         assign result.setpoint[k] = lshs_pkg::to_out(setpoint_in);
      end else begin : g_empty
         assign result.setpoint[k] = '0;
      end
   end

   assign result.status = status;

   lshs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (full)
   );

   assign rsp_setpoint_0 = rsp_data.setpoint[0];
   assign rsp_setpoint_1 = rsp_data.setpoint[1];
   assign rsp_setpoint_2 = rsp_data.setpoint[2];
   assign rsp_setpoint_3 = rsp_data.setpoint[3];
   assign rsp_setpoint_4 = rsp_data.setpoint[4];
   assign rsp_setpoint_5 = rsp_data.setpoint[5];
   assign rsp_setpoint_6 = rsp_data.setpoint[6];
   assign rsp_setpoint_7 = rsp_data.setpoint[7];
   assign rsp_phase      = rsp_data.status.phase;
   assign rsp_busy_res   = rsp_data.status.busy;
   assign rsp_done_res   = rsp_data.status.done;

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res
         && (rsp_phase == lshs_pkg::PHASE_OUT_W'(lshs_pkg::NUM_PHASES)))
      else $error("done result while busy or short of the last phase");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      full |-> rsp_valid)
      else $error("skid entry holds a word while the output register is empty");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      accept && (func == lshs_pkg::FUNC_START) |=> running)
      else $error("start word did not begin a homing sequence");

   a_tick_needs_run: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |-> running)
      else $error("lanes stepped while no sequence runs");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the limit switch homing sequencer unit
// Drives load, start, tick and unused words with random gaps and receiver
// stalls, predicts each result word in a scoreboard that keeps its own copy
// of the eight setpoints, the phase and the step registers, and compares
// every field of every result word with the oldest prediction. Step
// registers are rewritten between segments of the run, extremes included.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [lshs_pkg::FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
   localparam logic [lshs_pkg::REG_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int SEGMENTS     = 5;
   localparam int SEGMENT_WORDS = 360;
   localparam int HOLD_CYCLES  = 80;

   class homing_scoreboard;
      logic [lshs_pkg::SETPOINT_WIDTH-1:0] axis_pos [lshs_pkg::NUM_AXES];
      logic [lshs_pkg::PHASE_OUT_W-1:0]    cur_phase;
      bit                                  seq_running;
      logic [lshs_pkg::STEP_W-1:0]         step_size [lshs_pkg::NUM_REGS];
      lshs_pkg::result_type                pending_results [$];
      int                                  fails;

      function new();
         fails = 0;
         reset_state();
      endfunction

      function void reset_state();
         for (int k = 0; k < lshs_pkg::NUM_AXES; k++) axis_pos[k] = '0;
         step_size[0] = 16'd5;
         step_size[1] = 16'd5;
         step_size[2] = 16'd5;
         step_size[3] = 16'd1;
         step_size[4] = 16'd1;
         step_size[5] = 16'd1;
         cur_phase = '0;
         seq_running = 1'b0;
         pending_results.delete();
      endfunction

      function void write_step(logic [lshs_pkg::REG_IDX_W-1:0] idx,
                               logic [lshs_pkg::STEP_W-1:0] data);
         if (idx < lshs_pkg::REG_IDX_W'(lshs_pkg::NUM_REGS)) step_size[idx] = data;
      endfunction

      function void note_word(logic [lshs_pkg::FUNC_W-1:0] f,
                              logic [lshs_pkg::AXIS_W-1:0] a,
                              logic [lshs_pkg::VALUE_W-1:0] v,
                              logic [lshs_pkg::NUM_SWITCHES-1:0] sw);
         lshs_pkg::result_type        r;
         logic [lshs_pkg::STEP_W-1:0] st;
         bit                          outward;
         int                          ones;
         bit                          finished;
         finished = 1'b0;
         if (f == lshs_pkg::FUNC_LOAD) begin
            axis_pos[a] = v;
         end else if (f == lshs_pkg::FUNC_START) begin
            cur_phase = '0;
            seq_running = 1'b1;
         end else if (f == lshs_pkg::FUNC_TICK && seq_running) begin
            st = step_size[(cur_phase < lshs_pkg::PHASE_OUT_W'(lshs_pkg::NUM_REGS)) ?
                           cur_phase : lshs_pkg::PHASE_OUT_W'(lshs_pkg::NUM_REGS - 1)];
            outward = ~cur_phase[0];
            ones = 0;
            for (int k = 0; k < lshs_pkg::NUM_AXES; k++) begin
               if (sw[k]) ones++;
               if (outward && !sw[k])
                  axis_pos[k] = axis_pos[k] + lshs_pkg::SETPOINT_WIDTH'(st);
               else if (!outward && sw[k])
                  axis_pos[k] = axis_pos[k] - lshs_pkg::SETPOINT_WIDTH'(st);
            end
            if ((outward && ones == lshs_pkg::NUM_AXES) || (!outward && ones == 0)) begin
               cur_phase = cur_phase + 1'b1;
               if (cur_phase >= lshs_pkg::NUM_PHASES) begin
                  cur_phase = lshs_pkg::PHASE_OUT_W'(lshs_pkg::NUM_PHASES);
                  seq_running = 1'b0;
                  finished = 1'b1;
               end
            end
         end
         for (int k = 0; k < lshs_pkg::OUT_AXES; k++) r.setpoint[k] = axis_pos[k];
         r.status.phase = cur_phase;
         r.status.busy = seq_running;
         r.status.done = finished;
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         fails++;
         $display("mismatch: %s", msg);
      endtask

      task check_word(lshs_pkg::result_type got);
         lshs_pkg::result_type want;
         if (pending_results.size() == 0) begin
            report("result word with none expected");
            return;
         end
         want = pending_results.pop_front();
         for (int k = 0; k < lshs_pkg::OUT_AXES; k++)
            if (got.setpoint[k] !== want.setpoint[k])
               report($sformatf("setpoint_%0d got %h want %h", k, got.setpoint[k],
                                want.setpoint[k]));
         if (got.status.phase !== want.status.phase)
            report($sformatf("phase got %0d want %0d", got.status.phase, want.status.phase));
         if (got.status.busy !== want.status.busy)
            report($sformatf("busy_res got %b want %b", got.status.busy, want.status.busy));
         if (got.status.done !== want.status.done)
            report($sformatf("done_res got %b want %b", got.status.done, want.status.done));
      endtask

      function int pending_count();
         return pending_results.size();
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [lshs_pkg::FUNC_W-1:0]           req_func;
   logic [lshs_pkg::AXIS_W-1:0]           req_axis;
   logic signed [lshs_pkg::VALUE_W-1:0]   req_value;
   logic [lshs_pkg::NUM_SWITCHES-1:0]     req_switches;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_0;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_1;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_2;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_3;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_4;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_5;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_6;
   logic signed [lshs_pkg::OUT_W-1:0]     rsp_setpoint_7;
   logic [lshs_pkg::PHASE_OUT_W-1:0]      rsp_phase;
   logic                                  rsp_busy_res;
   logic                                  rsp_done_res;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [lshs_pkg::REG_IDX_W-1:0]        csr_index;
   logic [lshs_pkg::STEP_W-1:0]           csr_wdata;

   homing_scoreboard sb;
   bit               quiet;
   bit               hold_rsp;
   int               stall_left;

   limit_switch_homing_sequencer_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_axis       (req_axis),
      .req_value      (req_value),
      .req_switches   (req_switches),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_setpoint_0 (rsp_setpoint_0),
      .rsp_setpoint_1 (rsp_setpoint_1),
      .rsp_setpoint_2 (rsp_setpoint_2),
      .rsp_setpoint_3 (rsp_setpoint_3),
      .rsp_setpoint_4 (rsp_setpoint_4),
      .rsp_setpoint_5 (rsp_setpoint_5),
      .rsp_setpoint_6 (rsp_setpoint_6),
      .rsp_setpoint_7 (rsp_setpoint_7),
      .rsp_phase      (rsp_phase),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // result side: sample at the rising edge, pick the stall at the falling edge
   initial begin
      lshs_pkg::result_type got;
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.setpoint[0] = rsp_setpoint_0;
            got.setpoint[1] = rsp_setpoint_1;
            got.setpoint[2] = rsp_setpoint_2;
            got.setpoint[3] = rsp_setpoint_3;
            got.setpoint[4] = rsp_setpoint_4;
            got.setpoint[5] = rsp_setpoint_5;
            got.setpoint[6] = rsp_setpoint_6;
            got.setpoint[7] = rsp_setpoint_7;
            got.status.phase = rsp_phase;
            got.status.busy = rsp_busy_res;
            got.status.done = rsp_done_res;
            sb.check_word(got);
         end
         @(negedge clock);
         if (hold_rsp) begin
            // hold off long enough to back up the input
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 10)
            stall_left = $urandom_range(1, 14);
         rsp_stall = (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic drive_word(input logic [lshs_pkg::FUNC_W-1:0] f,
                             input logic [lshs_pkg::AXIS_W-1:0] a,
                             input logic [lshs_pkg::VALUE_W-1:0] v,
                             input logic [lshs_pkg::NUM_SWITCHES-1:0] sw);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = f;
      req_axis = a;
      req_value = v;
      req_switches = sw;
      do @(posedge clock); while (req_stall);
      sb.note_word(f, a, v, sw);
   endtask

   task automatic csr_write(input logic [lshs_pkg::REG_IDX_W-1:0] idx,
                            input logic [lshs_pkg::STEP_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_step(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drop valid and wait out every result word plus the output latency
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending_count() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input int seg);
      for (int i = 0; i < lshs_pkg::NUM_REGS; i++) begin
         case (seg)
            0:       csr_write(lshs_pkg::REG_IDX_W'(i), 16'h0000);
            1:       csr_write(lshs_pkg::REG_IDX_W'(i), 16'hFFFF);
            2:       csr_write(lshs_pkg::REG_IDX_W'(i), 16'($urandom_range(0, 65535)));
            3:       csr_write(lshs_pkg::REG_IDX_W'(i), 16'($urandom_range(0, 9)));
            default: csr_write(lshs_pkg::REG_IDX_W'(i),
                               (i % 2 == 0) ? 16'hFFFF : 16'h0001);
         endcase
      end
      if (seg == 3) csr_write(CSR_UNMAPPED, 16'hFFFF);
   endtask

   function automatic logic [lshs_pkg::VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h7FFF_FFF0;
         default: return $urandom();
      endcase
   endfunction

   // lean toward the pattern that ends the current phase
   function automatic logic [lshs_pkg::NUM_SWITCHES-1:0] rand_switches();
      int                                r;
      logic [lshs_pkg::NUM_SWITCHES-1:0] goal;
      r = $urandom_range(0, 99);
      goal = sb.cur_phase[0] ? 8'h00 : 8'hFF;
      if (r < 40) return goal;
      else if (r < 50) return ~goal;
      else if (r < 60) return goal ^ (8'h01 << $urandom_range(0, 7));
      else return 8'($urandom());
   endfunction

   task automatic random_word();
      int                          pick;
      logic [lshs_pkg::FUNC_W-1:0] f;
      pick = $urandom_range(0, 99);
      if (!sb.seq_running)
         f = (pick < 40) ? lshs_pkg::FUNC_START : (pick < 80) ? lshs_pkg::FUNC_TICK :
             (pick < 97) ? lshs_pkg::FUNC_LOAD : FUNC_UNUSED;
      else
         f = (pick < 3) ? lshs_pkg::FUNC_START : (pick < 12) ? lshs_pkg::FUNC_LOAD :
             (pick < 14) ? FUNC_UNUSED : lshs_pkg::FUNC_TICK;
      drive_word(f, 3'($urandom_range(0, 7)), rand_value(), rand_switches());
   endtask

   task automatic directed_words();
      drive_word(lshs_pkg::FUNC_LOAD, 3'd0, 32'h7FFF_FFFF, 8'h00);
      drive_word(lshs_pkg::FUNC_LOAD, 3'd7, 32'h8000_0000, 8'hFF);
      drive_word(lshs_pkg::FUNC_LOAD, 3'd3, 32'hFFFF_FFFF, 8'h00);
      drive_word(lshs_pkg::FUNC_LOAD, 3'd5, 32'h0000_0000, 8'h00);
      drive_word(lshs_pkg::FUNC_LOAD, 3'd1, 32'hFFFF_FFFD, 8'h00);
      // tick while idle, unused code
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hFF);
      drive_word(FUNC_UNUSED, 3'd7, 32'hFFFF_FFFF, 8'hFF);
      drive_word(lshs_pkg::FUNC_START, 3'd0, 32'h0, 8'h00);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h00);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hA5);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hFF);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hFF);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h5A);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h00);
      // restart while running, then load while running
      drive_word(lshs_pkg::FUNC_START, 3'd0, 32'h0, 8'h00);
      drive_word(lshs_pkg::FUNC_LOAD, 3'd6, 32'h7FFF_FFFE, 8'h00);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hFF);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h00);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hFF);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h00);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'hFF);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h00);
      drive_word(lshs_pkg::FUNC_TICK, 3'd0, 32'h0, 8'h00);
   endtask

   initial begin
      sb = new();
      quiet = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = lshs_pkg::FUNC_LOAD;
      req_axis = '0;
      req_value = '0;
      req_switches = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_words();
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         configure(seg);
         quiet = (seg == SEGMENTS - 1);
         for (int n = 0; n < SEGMENT_WORDS; n++) begin
            if (seg == 1 && n == 100) hold_rsp = 1'b1;
            random_word();
         end
      end
      settle();
      repeat (10) @(posedge clock);
      if (sb.fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
